/* rtl/pva_pkg.sv */
// Shared constants, types and codes of the voice allocator.
package pva_pkg;

  localparam int NUM_VOICES = 8;
  localparam int VIDX_W     = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int MAP_W      = 4;
  localparam int NOTE_W     = 8;
  localparam int VEL_W      = 7;
  localparam int TIME_W     = 32;
  localparam int VOICE_W    = 3;
  localparam int NOTE_COUNT = 1 << NOTE_W;

  localparam logic CMD_NOTE_ON  = 1'b0;
  localparam logic CMD_NOTE_OFF = 1'b1;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_START   = 2'd1,
    ACT_RELEASE = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP,
    S_SCAN,
    S_PICK,
    S_OLD,
    S_OFF,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [NOTE_W-1:0] note;
    logic [TIME_W-1:0] tstamp;
  } voice_entry_t;

endpackage

/* rtl/poly_voice_allocator_top.sv */
// Polyphonic voice allocator with oldest-voice stealing, memory based.
// Events: a note-on for an unmapped note scans every voice entry before its result;
//   a release or an event with no action skips the scan. One event at a time.
// Throughput: the next event is accepted only after the result has moved to the
//   output register; the scan reads one voice entry a cycle.
// Reset: synchronous, active high; clears all map and voice valid bits at once.
module poly_voice_allocator_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        cmd,
  input  logic [pva_pkg::NOTE_W-1:0]  note,
  input  logic [pva_pkg::VEL_W-1:0]   velocity,
  input  logic [pva_pkg::TIME_W-1:0]  time_stamp,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  action,
  output logic [pva_pkg::VOICE_W-1:0] voice,
  output logic [pva_pkg::NOTE_W-1:0]  voice_note,
  output logic [pva_pkg::VEL_W-1:0]   voice_velocity
);
  import pva_pkg::*;

  localparam logic [VIDX_W-1:0] LAST_VOICE = VIDX_W'(NUM_VOICES - 1);

  state_t state, state_next;

  // event registers
  logic              cmd_r;
  logic [NOTE_W-1:0] note_r;
  logic [VEL_W-1:0]  vel_r;
  logic [TIME_W-1:0] ts_r;

  // scan registers
  logic [VIDX_W-1:0] scan_cnt;
  logic [VIDX_W-1:0] best_idx;
  logic              best_busy;
  logic [TIME_W-1:0] best_time;
  logic [NOTE_W-1:0] best_note;

  // pending result
  action_t            res_action;
  logic [MAP_W-1:0]   res_voice;
  logic [NOTE_W-1:0]  res_note;
  logic [VEL_W-1:0]   res_vel;

  // memories
  logic [MAP_W-1:0]  map_mem [NOTE_COUNT];
  logic [MAP_W-1:0]  map_q;
  logic [NOTE_COUNT-1:0] map_vld;
  logic [NOTE_COUNT-1:0] map_vld_next;
  voice_entry_t      vmem [NUM_VOICES];
  voice_entry_t      vq;
  logic [NUM_VOICES-1:0] vvld;

  // control
  logic              accept;
  logic              out_free;
  logic [NOTE_W-1:0] map_raddr;
  logic              map_we;
  logic [VIDX_W-1:0] v_raddr;
  logic              v_we;
  logic [VIDX_W-1:0] v_waddr;
  voice_entry_t      v_wdata;
  logic              hit;
  logic              cur_busy;
  logic [TIME_W-1:0] cur_time;
  logic [NOTE_W-1:0] cur_note;
  logic              better;
  logic [VIDX_W-1:0] off_idx;
  logic [TIME_W-1:0] off_time;
  logic [MAP_W-1:0]  voice_ext;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign hit      = map_vld[note_r];
  assign off_idx  = map_q[VIDX_W-1:0];

  // decode the voice entry under scan; invalid entries read as idle at time zero
  assign cur_note = vvld[scan_cnt] ? vq.note : '0;
  assign cur_busy = (cur_note != '0);
  assign cur_time = vvld[scan_cnt] ? vq.tstamp : '0;
  assign better   = (scan_cnt == '0) ||
                    (!cur_busy && best_busy) ||
                    ((cur_busy == best_busy) && (cur_time < best_time));
  assign off_time = vvld[best_idx] ? vq.tstamp : '0;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_MAP;
      S_MAP: begin
        if ((cmd_r == CMD_NOTE_OFF) && hit)       state_next = S_OFF;
        else if ((cmd_r == CMD_NOTE_ON) && !hit)  state_next = S_SCAN;
        else                                      state_next = S_OUT;
      end
      S_SCAN: if (scan_cnt == LAST_VOICE) state_next = S_PICK;
      S_PICK: state_next = S_OLD;
      S_OLD:  state_next = S_OUT;
      S_OFF:  state_next = S_OUT;
      S_OUT:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory ports and handshake
  always_comb begin
    in_stall  = 1'b1;
    map_raddr = note;
    map_we    = 1'b0;
    v_raddr   = '0;
    v_we      = 1'b0;
    v_waddr   = best_idx;
    v_wdata   = '{note: note_r, tstamp: ts_r};
    unique case (state)
      S_IDLE: in_stall = 1'b0;
      S_MAP:  v_raddr = (cmd_r == CMD_NOTE_OFF) ? off_idx : '0;
      S_SCAN: v_raddr = scan_cnt + 1'b1;
      S_PICK: map_raddr = best_note;
      S_OLD: begin
        map_we = 1'b1;
        v_we   = 1'b1;
      end
      S_OFF: begin
        v_we    = 1'b1;
        v_wdata = '{note: '0, tstamp: off_time};
      end
      S_OUT: ;
      default: ;
    endcase
  end

  // map memory: voice index per note, registered read
  always_ff @(posedge clk) begin
    if (map_we) map_mem[note_r] <= MAP_W'(best_idx);
    map_q <= map_mem[map_raddr];
  end

  // voice memory: current note and start time per voice, registered read
  always_ff @(posedge clk) begin
    if (v_we) vmem[v_waddr] <= v_wdata;
    vq <= vmem[v_raddr];
  end

  // map valid bits: a release unmaps its note; a start unmaps the stolen voice's old note before mapping the new one
  always_comb begin
    map_vld_next = map_vld;
    if (state == S_MAP && (cmd_r == CMD_NOTE_OFF) && hit) map_vld_next[note_r] = 1'b0;
    if (state == S_OLD) begin
      if (map_vld[best_note] && (map_q == MAP_W'(best_idx))) map_vld_next[best_note] = 1'b0;
      map_vld_next[note_r] = 1'b1;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      map_vld <= '0;
      vvld    <= '0;
    end else begin
      map_vld <= map_vld_next;
      if (v_we) vvld[v_waddr] <= 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // capture the event
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= cmd;
      note_r <= note;
      vel_r  <= velocity;
      ts_r   <= time_stamp;
    end
  end

  // scan voices: keep the best candidate, advance one voice a cycle
  always_ff @(posedge clk) begin
    if (state == S_MAP) begin
      scan_cnt <= '0;
      best_idx <= off_idx;
    end
    if (state == S_SCAN) begin
      scan_cnt <= scan_cnt + 1'b1;
      if (better) begin
        best_idx  <= scan_cnt;
        best_busy <= cur_busy;
        best_time <= cur_time;
        best_note <= cur_note;
      end
    end
  end

  // form the result
  always_ff @(posedge clk) begin
    unique case (state)
      S_MAP: begin
        res_action <= ACT_NONE;
        res_voice  <= '0;
        res_note   <= '0;
        res_vel    <= '0;
      end
      S_OLD: begin
        res_action <= ACT_START;
        res_voice  <= MAP_W'(best_idx);
        res_note   <= note_r;
        res_vel    <= vel_r;
      end
      S_OFF: begin
        res_action <= ACT_RELEASE;
        res_voice  <= MAP_W'(best_idx);
        res_note   <= note_r;
        res_vel    <= '0;
      end
      default: ;
    endcase
  end

  // output register: hold the beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      action         <= res_action;
      voice_ext      <= res_voice;
      voice_note     <= res_note;
      voice_velocity <= res_vel;
    end
  end

  assign voice = voice_ext[VOICE_W-1:0];

`ifndef ASSERT_OFF
  a_accept_to_map: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_MAP)
    else $error("accepted beat did not start a map lookup");

  a_release_vel: assert property (@(posedge clk) disable iff (rst)
    out_valid && action == ACT_RELEASE |-> voice_velocity == '0)
    else $error("release beat carries a velocity");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && action == ACT_NONE |-> voice == '0 && voice_note == '0)
    else $error("empty beat carries a voice or note");

  a_start_maps: assert property (@(posedge clk) disable iff (rst)
    state == S_OLD |=> map_vld[$past(note_r)])
    else $error("started note left unmapped");
`endif

endmodule
